>>> hdl/transaction_response_bitmap_tracker_assert.svh
// assertion macros for the tracker rtl, included by the engine
`ifndef TRANSACTION_RESPONSE_BITMAP_TRACKER_ASSERT_SVH
`define TRANSACTION_RESPONSE_BITMAP_TRACKER_ASSERT_SVH

// checked only outside reset
`define TRBT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TRBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/trbt_pkg.sv
// types and constants of the transaction response bitmap tracker
package trbt_pkg;

   localparam int RESPONSE_SLOTS = 8;
   localparam int SEQ_WIDTH      = $clog2(RESPONSE_SLOTS);
   localparam int TID_WIDTH      = 16;
   localparam int TRIES_WIDTH    = 9;
   localparam int SECONDS_WIDTH  = 8;

   localparam logic [TRIES_WIDTH-1:0]   TRIES_INFINITE  = '1;
   localparam logic [SECONDS_WIDTH-1:0] SECONDS_MAX     = '1;
   localparam logic [SECONDS_WIDTH-1:0] TIMEOUT_RESET   = 8'd2;

   typedef logic [RESPONSE_SLOTS-1:0] bitmap_type;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_RESPONSE = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_UNUSED   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_TIMEOUT  = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef struct packed {
      action_type                    action;
      logic [TID_WIDTH-1:0]          txn_id;
      logic [SEQ_WIDTH-1:0]          seq_num;
      logic                          end_of_message;
      logic                          send_status;
      bitmap_type                    start_bitmap;
      logic signed [TRIES_WIDTH-1:0] start_tries;
      logic                          exactly_once;
   } req_payload_type;

   typedef struct packed {
      logic       send_request;
      bitmap_type request_bitmap;
      logic       send_release;
      logic       store_response;
      status_type status;
   } rsp_payload_type;

endpackage

>>> hdl/trbt_req_if.sv
// request channel: events into the tracker
interface trbt_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             action;
   logic [trbt_pkg::TID_WIDTH-1:0]         txn_id;
   logic [trbt_pkg::SEQ_WIDTH-1:0]         seq_num;
   logic                                   end_of_message;
   logic                                   send_status;
   logic [trbt_pkg::RESPONSE_SLOTS-1:0]    start_bitmap;
   logic signed [trbt_pkg::TRIES_WIDTH-1:0] start_tries;
   logic                                   exactly_once;

   modport source (
      output valid, action, txn_id, seq_num, end_of_message, send_status,
             start_bitmap, start_tries, exactly_once,
      input  ready
   );

   modport sink (
      input  valid, action, txn_id, seq_num, end_of_message, send_status,
             start_bitmap, start_tries, exactly_once,
      output ready
   );
endinterface

>>> hdl/trbt_rsp_if.sv
// response channel: one result beat per event
interface trbt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                send_request;
   logic [trbt_pkg::RESPONSE_SLOTS-1:0] request_bitmap;
   logic                                send_release;
   logic                                store_response;
   logic [1:0]                          status;

   modport source (
      output valid, send_request, request_bitmap, send_release, store_response, status,
      input  ready
   );

   modport sink (
      input  valid, send_request, request_bitmap, send_release, store_response, status,
      output ready
   );
endinterface

>>> hdl/trbt_in_stage.sv
// input register: captures one request beat per cycle while it is empty or its held beat is taken
module trbt_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   trbt_req_if.sink                   req_bus,
   input  logic                       item_take,
   output logic                       item_valid,
   output trbt_pkg::req_payload_type  item
);

   logic                      valid_ff, valid_in;
   trbt_pkg::req_payload_type item_ff, item_in;
   logic                      accept;

   assign req_bus.ready = !valid_ff || item_take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (item_take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in               = 1'b1;
         item_in.action         = trbt_pkg::action_type'(req_bus.action);
         item_in.txn_id         = req_bus.txn_id;
         item_in.seq_num        = req_bus.seq_num;
         item_in.end_of_message = req_bus.end_of_message;
         item_in.send_status    = req_bus.send_status;
         item_in.start_bitmap   = req_bus.start_bitmap;
         item_in.start_tries    = req_bus.start_tries;
         item_in.exactly_once   = req_bus.exactly_once;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hdl/trbt_engine.sv
// transaction state and per-event decision logic
`include "transaction_response_bitmap_tracker_assert.svh"

module trbt_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [trbt_pkg::SECONDS_WIDTH-1:0] csr_write_data,
   input  logic                              advance,
   input  trbt_pkg::req_payload_type         item,
   output trbt_pkg::rsp_payload_type         result
);

   logic [trbt_pkg::SECONDS_WIDTH-1:0] timeout_ff, timeout_in;
   trbt_pkg::bitmap_type               pending_ff, pending_in;
   logic [trbt_pkg::TID_WIDTH-1:0]     tid_ff, tid_in;
   logic [trbt_pkg::TRIES_WIDTH-1:0]   tries_ff, tries_in;
   logic                               xo_ff, xo_in;
   logic [trbt_pkg::SECONDS_WIDTH-1:0] seconds_ff, seconds_in;
   logic                               active_ff, active_in;

   trbt_pkg::bitmap_type               seq_bit;
   trbt_pkg::bitmap_type               resp_bitmap;
   logic                               resp_hit;
   logic [trbt_pkg::SECONDS_WIDTH-1:0] seconds_inc;
   logic                               tries_ok;
   logic [trbt_pkg::TRIES_WIDTH-1:0]   start_tries_fixed;

   assign seq_bit  = trbt_pkg::bitmap_type'(1) << item.seq_num;
   assign resp_hit = active_ff && ((pending_ff & seq_bit) != '0) && (item.txn_id == tid_ff);
   // end-of-message keeps only the bits below this sequence
   assign resp_bitmap = item.end_of_message ? (pending_ff & (seq_bit - 1'b1))
                                            : (pending_ff & ~seq_bit);
   assign seconds_inc = (seconds_ff == trbt_pkg::SECONDS_MAX) ? seconds_ff
                                                              : seconds_ff + 1'b1;
   assign tries_ok = (tries_ff == trbt_pkg::TRIES_INFINITE) ||
                     ((tries_ff != '0) && !tries_ff[trbt_pkg::TRIES_WIDTH-1]);
   // negative counts other than infinite mean no retries
   assign start_tries_fixed =
      (item.start_tries[trbt_pkg::TRIES_WIDTH-1] &&
       (item.start_tries != trbt_pkg::TRIES_INFINITE)) ? '0 : item.start_tries;

   always_comb begin
      timeout_in = csr_write_en ? csr_write_data : timeout_ff;
      pending_in = pending_ff;
      tid_in     = tid_ff;
      tries_in   = tries_ff;
      xo_in      = xo_ff;
      seconds_in = seconds_ff;
      active_in  = active_ff;
      result     = '0;
      result.status = trbt_pkg::ST_IGNORED;
      if (advance) begin
         unique case (item.action)
            trbt_pkg::ACT_START: begin
               tid_in                = item.txn_id;
               pending_in            = item.start_bitmap;
               tries_in              = start_tries_fixed;
               xo_in                 = item.exactly_once;
               seconds_in            = '0;
               result.send_request   = 1'b1;
               result.request_bitmap = item.start_bitmap;
               if (item.start_bitmap == '0) begin
                  active_in     = 1'b0;
                  result.status = trbt_pkg::ST_COMPLETE;
               end else begin
                  active_in     = 1'b1;
                  result.status = trbt_pkg::ST_PENDING;
               end
            end
            trbt_pkg::ACT_RESPONSE: begin
               if (resp_hit) begin
                  pending_in            = resp_bitmap;
                  result.store_response = 1'b1;
                  if (item.send_status) begin
                     result.send_request   = 1'b1;
                     result.request_bitmap = resp_bitmap;
                  end
                  if (resp_bitmap == '0) begin
                     active_in           = 1'b0;
                     result.send_release = xo_ff;
                     result.status       = trbt_pkg::ST_COMPLETE;
                  end else begin
                     result.status = trbt_pkg::ST_PENDING;
                  end
               end
            end
            trbt_pkg::ACT_TICK: begin
               if (active_ff) begin
                  seconds_in    = seconds_inc;
                  result.status = trbt_pkg::ST_PENDING;
                  if (seconds_inc > timeout_ff) begin
                     if (tries_ok) begin
                        result.send_request   = 1'b1;
                        result.request_bitmap = pending_ff;
                        seconds_in            = '0;
                        if (tries_ff != trbt_pkg::TRIES_INFINITE) begin
                           tries_in = tries_ff - 1'b1;
                        end
                     end else begin
                        active_in     = 1'b0;
                        result.status = trbt_pkg::ST_TIMEOUT;
                     end
                  end
               end
            end
            trbt_pkg::ACT_UNUSED: begin
               result.status = trbt_pkg::ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= trbt_pkg::TIMEOUT_RESET;
         pending_ff <= '0;
         tid_ff     <= '0;
         tries_ff   <= '0;
         xo_ff      <= 1'b0;
         seconds_ff <= '0;
         active_ff  <= 1'b0;
      end else begin
         timeout_ff <= timeout_in;
         pending_ff <= pending_in;
         tid_ff     <= tid_in;
         tries_ff   <= tries_in;
         xo_ff      <= xo_in;
         seconds_ff <= seconds_in;
         active_ff  <= active_in;
      end
   end

   `TRBT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!active_ff && pending_ff == '0), "tracker not idle after reset")
   `TRBT_ASSERT(a_active_has_pending, clock, reset, active_ff |-> (pending_ff != '0), "active transaction with empty bitmap")
   `TRBT_ASSERT(a_store_needs_active, clock, reset, (advance && result.store_response) |-> active_ff, "response stored with no transaction")
   `TRBT_ASSERT(a_timeout_ends, clock, reset, (advance && result.status == trbt_pkg::ST_TIMEOUT) |=> !active_ff, "transaction still active after timeout")

endmodule

>>> hdl/trbt_out_stage.sv
// result register toward the response channel
module trbt_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  trbt_pkg::rsp_payload_type data,
   output logic                      can_load,
   trbt_rsp_if.source                rsp_bus
);

   logic                      valid_ff, valid_in;
   trbt_pkg::rsp_payload_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid          = valid_ff;
   assign rsp_bus.send_request   = data_ff.send_request;
   assign rsp_bus.request_bitmap = data_ff.request_bitmap;
   assign rsp_bus.send_release   = data_ff.send_release;
   assign rsp_bus.store_response = data_ff.store_response;
   assign rsp_bus.status         = data_ff.status;

endmodule

>>> hdl/transaction_response_bitmap_tracker.sv
// request beats are registered at the input, results registered again at the output
// throughput: one event per cycle while the output register can take each result
// an empty input register takes a beat while a result waits in the output register
// reset: synchronous, clears the transaction state, both stages empty, timeout back to 2
// no clearing pass; events are taken in the first cycle after reset
module transaction_response_bitmap_tracker (
   input  logic                               clock,
   input  logic                               reset,
   trbt_req_if.sink                           req_bus,
   trbt_rsp_if.source                         rsp_bus,
   input  logic                               csr_write_en,
   input  logic [trbt_pkg::SECONDS_WIDTH-1:0] csr_write_data
);

   logic                      item_valid;
   logic                      can_load;
   logic                      advance;
   trbt_pkg::req_payload_type item;
   trbt_pkg::rsp_payload_type result;

   // an event is processed when the output register can take its result
   assign advance = item_valid && can_load;

   trbt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_take  (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   trbt_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .advance        (advance),
      .item           (item),
      .result         (result)
   );

   trbt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .data     (result),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> sim/trbt_tracker_checker.sv
// scoreboard for the tracker: mirrors the transaction state and checks every result beat
module trbt_tracker_checker
   import trbt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   trbt_req_if                      req_bus,
   trbt_rsp_if                      rsp_bus,
   input  logic                     csr_write_en,
   input  logic [SECONDS_WIDTH-1:0] csr_write_data,
   output int                       fail_count,
   output int                       results_due
);

   logic [SECONDS_WIDTH-1:0] timeout_secs;
   bitmap_type               wanted;
   logic [TID_WIDTH-1:0]     open_tid;
   logic [TRIES_WIDTH-1:0]   retries;
   logic                     release_needed;
   logic [SECONDS_WIDTH-1:0] idle_secs;
   logic                     in_flight;
   rsp_payload_type          due_results[$];
   int                       errors = 0;

   // next result of the tracker for one event, updating the mirrored state
   function automatic rsp_payload_type track_event(input req_payload_type ev);
      rsp_payload_type r;
      bitmap_type      seq_bit;
      r = '0;
      r.status = ST_IGNORED;
      case (ev.action)
         ACT_START: begin
            open_tid = ev.txn_id;
            wanted = ev.start_bitmap;
            // negative counts other than infinite mean no retries
            if (ev.start_tries[TRIES_WIDTH-1] && ev.start_tries != TRIES_INFINITE)
               retries = '0;
            else
               retries = ev.start_tries;
            release_needed = ev.exactly_once;
            idle_secs = '0;
            r.send_request = 1'b1;
            r.request_bitmap = ev.start_bitmap;
            in_flight = (ev.start_bitmap != '0);
            r.status = in_flight ? ST_PENDING : ST_COMPLETE;
         end
         ACT_RESPONSE: begin
            seq_bit = bitmap_type'(1) << ev.seq_num;
            if (in_flight && (wanted & seq_bit) != '0 && ev.txn_id == open_tid) begin
               wanted &= ~seq_bit;
               r.store_response = 1'b1;
               if (ev.end_of_message)
                  wanted &= (seq_bit | (seq_bit - 1'b1));
               if (ev.send_status) begin
                  r.send_request = 1'b1;
                  r.request_bitmap = wanted;
               end
               if (wanted == '0) begin
                  in_flight = 1'b0;
                  r.send_release = release_needed;
                  r.status = ST_COMPLETE;
               end else begin
                  r.status = ST_PENDING;
               end
            end
         end
         ACT_TICK: begin
            if (in_flight) begin
               if (idle_secs != SECONDS_MAX)
                  idle_secs++;
               r.status = ST_PENDING;
               if (idle_secs > timeout_secs) begin
                  if (retries == TRIES_INFINITE || (retries != '0 && !retries[TRIES_WIDTH-1]))
                  begin
                     r.send_request = 1'b1;
                     r.request_bitmap = wanted;
                     idle_secs = '0;
                     if (retries != TRIES_INFINITE)
                        retries--;
                  end else begin
                     in_flight = 1'b0;
                     r.status = ST_TIMEOUT;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      req_payload_type ev;
      rsp_payload_type want;
      if (reset) begin
         timeout_secs = TIMEOUT_RESET;
         wanted = '0;
         open_tid = '0;
         retries = '0;
         release_needed = 1'b0;
         idle_secs = '0;
         in_flight = 1'b0;
         due_results.delete();
      end else begin
         if (csr_write_en)
            timeout_secs = csr_write_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               $error("result beat with no event waiting for it");
               errors++;
            end else begin
               want = due_results.pop_front();
               compare_field("send_request", want.send_request, rsp_bus.send_request);
               compare_field("request_bitmap", want.request_bitmap, rsp_bus.request_bitmap);
               compare_field("send_release", want.send_release, rsp_bus.send_release);
               compare_field("store_response", want.store_response, rsp_bus.store_response);
               compare_field("status", want.status, rsp_bus.status);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            ev.action = action_type'(req_bus.action);
            ev.txn_id = req_bus.txn_id;
            ev.seq_num = req_bus.seq_num;
            ev.end_of_message = req_bus.end_of_message;
            ev.send_status = req_bus.send_status;
            ev.start_bitmap = req_bus.start_bitmap;
            ev.start_tries = req_bus.start_tries;
            ev.exactly_once = req_bus.exactly_once;
            due_results.push_back(track_event(ev));
         end
      end
      fail_count <= errors;
      results_due <= due_results.size();
   end

endmodule

>>> sim/testbench.sv
// top of the tracker bench: clock, reset, event stimulus, result sink and verdict
module testbench;
   import trbt_pkg::*;

   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_EVENTS  = 90;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_write_en;
   logic [SECONDS_WIDTH-1:0] csr_write_data;
   int                       fail_count;
   int                       results_due;
   int                       events_sent = 0;
   int                       settings_used = 1;
   int                       cycles = 0;
   bit                       steady = 1'b0;
   bit                       hold_off_req = 1'b0;

   trbt_req_if req_bus();
   trbt_rsp_if rsp_bus();

   transaction_response_bitmap_tracker DUT (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   trbt_tracker_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .results_due    (results_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results outstanding",
                  cycles, results_due);
         $display("** transaction_response_bitmap_tracker: FAILED **");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, 17);
   endfunction

   // every field random, the action too
   function automatic req_payload_type noise_event();
      req_payload_type ev;
      ev.action = action_type'(2'($urandom_range(0, 3)));
      ev.txn_id = 16'($urandom);
      ev.seq_num = 3'($urandom);
      ev.end_of_message = 1'($urandom);
      ev.send_status = 1'($urandom);
      ev.start_bitmap = 8'($urandom);
      ev.start_tries = 9'($urandom);
      ev.exactly_once = 1'($urandom);
      return ev;
   endfunction

   function automatic req_payload_type start_event(input logic [TID_WIDTH-1:0] tid,
                                                   input bitmap_type bitmap,
                                                   input logic signed [TRIES_WIDTH-1:0] tries,
                                                   input logic xo);
      req_payload_type ev;
      ev = noise_event();
      ev.action = ACT_START;
      ev.txn_id = tid;
      ev.start_bitmap = bitmap;
      ev.start_tries = tries;
      ev.exactly_once = xo;
      return ev;
   endfunction

   function automatic req_payload_type response_event(input logic [TID_WIDTH-1:0] tid,
                                                      input int seq, input logic eom,
                                                      input logic sts);
      req_payload_type ev;
      ev = noise_event();
      ev.action = ACT_RESPONSE;
      ev.txn_id = tid;
      ev.seq_num = 3'(seq);
      ev.end_of_message = eom;
      ev.send_status = sts;
      return ev;
   endfunction

   function automatic req_payload_type tick_event();
      req_payload_type ev;
      ev = noise_event();
      ev.action = ACT_TICK;
      return ev;
   endfunction

   task automatic send_event(input req_payload_type ev);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= ev.action;
      req_bus.txn_id <= ev.txn_id;
      req_bus.seq_num <= ev.seq_num;
      req_bus.end_of_message <= ev.end_of_message;
      req_bus.send_status <= ev.send_status;
      req_bus.start_bitmap <= ev.start_bitmap;
      req_bus.start_tries <= ev.start_tries;
      req_bus.exactly_once <= ev.exactly_once;
      do @(posedge clock); while (!req_bus.ready);
      events_sent++;
   endtask

   // stop offering beats and wait for every result to come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [SECONDS_WIDTH-1:0] value);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // one transaction: start, then mostly responses for wanted slots, ticks and some noise
   task automatic run_transaction();
      logic [TID_WIDTH-1:0]          tid;
      bitmap_type                    left;
      logic signed [TRIES_WIDTH-1:0] tries;
      req_payload_type               ev;
      int                            seq;
      int                            pick;
      tid = 16'($urandom);
      left = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
      case ($urandom_range(0, 5))
         0: tries = -9'sd1;
         1: tries = 9'sd0;
         2: tries = 9'sd1;
         3: tries = 9'($urandom_range(256, 510));
         default: tries = 9'($urandom_range(0, 255));
      endcase
      steady = ($urandom_range(0, 4) == 0);
      send_event(start_event(tid, left, tries, 1'($urandom)));
      repeat ($urandom_range(2, 14)) begin
         pick = $urandom_range(0, 99);
         if (pick < 60 && left != '0) begin
            do seq = $urandom_range(0, 7); while (!left[seq]);
            ev = response_event(tid, seq, $urandom_range(0, 4) == 0, 1'($urandom));
            left[seq] = 1'b0;
            if (ev.end_of_message)
               left &= (8'(1 << seq) - 8'd1);
         end else if (pick < 85) begin
            ev = tick_event();
         end else if (pick < 93) begin
            // random slot, wrong id
            ev = response_event(tid ^ 16'(1 << $urandom_range(0, 15)), $urandom_range(0, 7),
                                1'($urandom), 1'($urandom));
         end else begin
            ev = noise_event();
         end
         send_event(ev);
      end
   endtask

   // result sink with random stalls and, on request, one long hold-off
   initial begin
      int stall;
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (hold_off_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = draw_wait();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      req_payload_type          ev;
      logic [SECONDS_WIDTH-1:0] timeouts [5];
      int                       phase_end;
      int                       txn_count;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_START;
      req_bus.txn_id <= '0;
      req_bus.seq_num <= '0;
      req_bus.end_of_message <= 1'b0;
      req_bus.send_status <= 1'b0;
      req_bus.start_bitmap <= '0;
      req_bus.start_tries <= '0;
      req_bus.exactly_once <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed events with the timeout at its reset value
      send_event(start_event(16'hFFFF, 8'hFF, -9'sd1, 1'b1));
      send_event(response_event(16'h0000, 0, 1'b0, 1'b1));   // wrong id
      send_event(response_event(16'hFFFF, 0, 1'b0, 1'b1));   // accepted, status resend
      send_event(response_event(16'hFFFF, 0, 1'b0, 1'b0));   // slot already in
      send_event(response_event(16'hFFFF, 3, 1'b1, 1'b1));   // end of message drops 4..7
      send_event(response_event(16'hFFFF, 7, 1'b0, 1'b0));   // dropped slot
      repeat (3) send_event(tick_event());                   // infinite tries resend
      send_event(response_event(16'hFFFF, 1, 1'b0, 1'b0));
      send_event(response_event(16'hFFFF, 2, 1'b0, 1'b1));   // completes with release
      send_event(tick_event());                              // tick while idle
      ev = noise_event();
      ev.action = ACT_UNUSED;
      send_event(ev);
      send_event(start_event(16'h0001, 8'h00, 9'sd3, 1'b1)); // empty bitmap
      send_event(start_event(16'h0000, 8'h80, 9'sd0, 1'b0));
      repeat (3) send_event(tick_event());                   // no retries: timeout
      send_event(response_event(16'h0000, 7, 1'b1, 1'b1));   // too late
      send_event(start_event(16'hA5A5, 8'h01, -9'sd256, 1'b0)); // odd negative count
      send_event(start_event(16'h5A5A, 8'h02, 9'sd1, 1'b1));    // replaces active one
      repeat (3) send_event(tick_event());                   // last retry goes out
      send_event(response_event(16'h5A5A, 1, 1'b1, 1'b1));   // accepted after last retry

      timeouts[0] = 8'd0;
      timeouts[1] = SECONDS_MAX;
      timeouts[2] = 8'd1;
      timeouts[3] = TIMEOUT_RESET;
      timeouts[4] = 8'($urandom_range(3, 254));
      for (int p = 0; p < 5; p++) begin
         write_timeout(timeouts[p]);
         phase_end = events_sent + PHASE_EVENTS;
         txn_count = 0;
         while (events_sent < phase_end) begin
            run_transaction();
            txn_count++;
            if (p == 2 && txn_count == 2)
               hold_off_req <= 1'b1;
            if (p == 3 && txn_count == 3)
               drain();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("tracker run: %0d event beats under %0d timeout settings (0 to 255),",
               events_sent, settings_used);
      $display("with long sink hold-off, idle drains and random stalls on both sides");
      if (fail_count == 0)
         $display("** transaction_response_bitmap_tracker: PASSED **");
      else
         $display("** transaction_response_bitmap_tracker: FAILED **");
      $finish;
   end

endmodule
